// File: src/lmf_pkg.sv
// Shared types and constants for the 3x3 local maximum filter.
// No dependencies; imported by every module of the block.
package lmf_pkg;

  localparam int MAX_SIDE     = 128;
  localparam int PIXEL_BITS   = 8;
  localparam int SIDE_BITS    = 8;
  localparam int COL_BITS     = $clog2(MAX_SIDE);
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

  localparam logic [SIDE_BITS-1:0] SIDE_MIN   = SIDE_BITS'(3);
  localparam logic [SIDE_BITS-1:0] SIDE_MAX   = SIDE_BITS'(MAX_SIDE);
  localparam logic [SIDE_BITS-1:0] SIDE_RESET = SIDE_BITS'(MAX_SIDE);

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [COL_BITS-1:0]   col_idx_t;

  // one window column: rows r-2, r-1, r
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    pixel_t local_max;
    logic   frame_end;
  } result_t;

  function automatic pixel_t pix_max(input pixel_t a, input pixel_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: src/lmf_line_store.sv
// Two line buffers (rows r-2 and r-1) indexed by column, registered read.
// Depends on lmf_pkg.
module lmf_line_store (
  input  logic              clk,
  input  logic              rd_en,
  input  lmf_pkg::col_idx_t rd_addr,
  input  logic              wr_en,
  input  lmf_pkg::col_idx_t wr_addr,
  input  lmf_pkg::pixel_t   wr_upper,
  input  lmf_pkg::pixel_t   wr_middle,
  output lmf_pkg::pixel_t   rd_upper,
  output lmf_pkg::pixel_t   rd_middle
);
  import lmf_pkg::*;

  pixel_t upper_mem  [MAX_SIDE];
  pixel_t middle_mem [MAX_SIDE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper  <= upper_mem[rd_addr];
      rd_middle <= middle_mem[rd_addr];
    end
  end

endmodule

// File: src/lmf_window_cell.sv
// One column of the 3x3 window: holds a column, passes it right on shift,
// and extends the running maximum coming from its left neighbor.
// Depends on lmf_pkg.
module lmf_window_cell (
  input  logic             clk,
  input  logic             shift,
  input  lmf_pkg::column_t col_in,
  input  lmf_pkg::pixel_t  run_in,
  output lmf_pkg::column_t col_out,
  output lmf_pkg::pixel_t  run_out
);
  import lmf_pkg::*;

  column_t col;

  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;
  assign run_out = pix_max(run_in, pix_max(col.top, pix_max(col.mid, col.bot)));

endmodule

// File: src/lmf_out_queue.sv
// Small result queue between the filter pipeline and the output channel.
// Depends on lmf_pkg.
module lmf_out_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  lmf_pkg::result_t                    push_data,
  input  logic                                pop,
  output logic                                not_empty,
  output lmf_pkg::result_t                    head,
  output logic [lmf_pkg::OUT_CNT_BITS-1:0]    count
);
  import lmf_pkg::*;

  result_t                 slots [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] wr_ptr;
  logic [OUT_PTR_BITS-1:0] rd_ptr;
  logic                    do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OUT_CNT_BITS'(push) - OUT_CNT_BITS'(do_pop);
    end
  end

endmodule

// File: src/local_max_filter_3x3_core.sv
// 3x3 local maximum filter, top level.
// Depends on lmf_pkg, lmf_line_store, lmf_window_cell, lmf_out_queue.
//
// Input channel: pixel with in_valid / in_stall, one request per pixel of a
// square frame in row-major order. Output channel: local_max and frame_end
// with out_valid / out_stall. A result comes out for every pixel at row >= 2
// and column >= 2; frame_end marks the last result of the frame.
// cfg_write / cfg_data set the image side (saturated to 3..128) and restart
// the frame at row 0, column 0; write it only while the block is idle.
//
// Path: a result goes through the line buffer read at the taking edge, the
// window load and the queue write before it is shown, and it can be taken
// from then on. Throughput: one pixel per cycle sustained while in_stall is low,
// set by the line buffer read/write and the three-cell window chain.
// A 4-entry result queue decouples the output; in_stall rises only when the
// queue plus the two pipeline stages could not absorb another result.
// Reset clears the position counters, pipeline and queue and sets the side
// to 128; line buffer contents are not cleared and need no clearing pass.
module local_max_filter_3x3_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [7:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               local_max,
  output logic                     frame_end
);
  import lmf_pkg::*;

  logic [SIDE_BITS-1:0] image_side;
  logic [SIDE_BITS-1:0] side_eff;
  col_idx_t             last_idx;
  col_idx_t             row_pos;
  col_idx_t             col_pos;
  col_idx_t             row_next;
  col_idx_t             col_next;
  logic                 accept;

  // stage 1: line buffer read outstanding
  logic     s1_valid;
  logic     s1_emit;
  logic     s1_last;
  col_idx_t s1_col;
  pixel_t   s1_pixel;
  pixel_t   rd_upper;
  pixel_t   rd_middle;

  // stage 2: window holds the finished neighborhood
  logic     s2_valid;
  logic     s2_last;

  column_t  new_col;
  column_t  col0;
  column_t  col1;
  column_t  col2_unused;
  pixel_t   run0;
  pixel_t   run1;
  pixel_t   win_max;

  result_t                 push_data;
  result_t                 head;
  logic                    q_not_empty;
  logic [OUT_CNT_BITS-1:0] q_count;
  logic [OUT_CNT_BITS:0]   pending;

  always_comb begin
    if (image_side < SIDE_MIN) begin
      side_eff = SIDE_MIN;
    end else if (image_side > SIDE_MAX) begin
      side_eff = SIDE_MAX;
    end else begin
      side_eff = image_side;
    end
  end

  assign last_idx = COL_BITS'(side_eff - SIDE_BITS'(1));

  assign pending  = (OUT_CNT_BITS + 1)'(q_count) + (OUT_CNT_BITS + 1)'(s1_valid)
                  + (OUT_CNT_BITS + 1)'(s2_valid);
  assign in_stall = (pending >= (OUT_CNT_BITS + 1)'(OUT_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    row_next = row_pos;
    col_next = col_pos + 1'b1;
    if (col_pos == last_idx) begin
      col_next = '0;
      row_next = (row_pos == last_idx) ? '0 : row_pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_side <= SIDE_RESET;
      row_pos    <= '0;
      col_pos    <= '0;
    end else if (cfg_write) begin
      image_side <= cfg_data;
      row_pos    <= '0;
      col_pos    <= '0;
    end else if (accept) begin
      row_pos <= row_next;
      col_pos <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= col_pos;
      s1_pixel <= pixel;
      s1_emit  <= (row_pos >= COL_BITS'(2)) && (col_pos >= COL_BITS'(2));
      s1_last  <= (row_pos == last_idx) && (col_pos == last_idx);
    end
    if (s1_valid) begin
      s2_last <= s1_last;
    end
  end

  // consecutive pixels hit different columns, so read and write never collide
  lmf_line_store u_lines (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (col_pos),
    .wr_en     (s1_valid),
    .wr_addr   (s1_col),
    .wr_upper  (rd_middle),
    .wr_middle (s1_pixel),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle)
  );

  assign new_col = '{top: rd_upper, mid: rd_middle, bot: s1_pixel};

  lmf_window_cell u_cell0 (
    .clk     (clk),
    .shift   (s1_valid),
    .col_in  (new_col),
    .run_in  ('0),
    .col_out (col0),
    .run_out (run0)
  );

  lmf_window_cell u_cell1 (
    .clk     (clk),
    .shift   (s1_valid),
    .col_in  (col0),
    .run_in  (run0),
    .col_out (col1),
    .run_out (run1)
  );

  lmf_window_cell u_cell2 (
    .clk     (clk),
    .shift   (s1_valid),
    .col_in  (col1),
    .run_in  (run1),
    .col_out (col2_unused),
    .run_out (win_max)
  );

  assign push_data = '{local_max: win_max, frame_end: s2_last};

  lmf_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (push_data),
    .pop       (!out_stall),
    .not_empty (q_not_empty),
    .head      (head),
    .count     (q_count)
  );

  assign out_valid = q_not_empty;
  assign local_max = head.local_max;
  assign frame_end = head.frame_end;

endmodule

// File: sim/max_window_checker.sv
// Scoreboard for the 3x3 local maximum filter: watches the side register and
// both channels, predicts every window maximum and compares it on arrival.
// Depends on lmf_pkg for pixel_t, result_t and the side limits.
module max_window_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] pixel,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] local_max,
  input  logic       frame_end,
  output int         fail_count,
  output int         pending,
  output int         maxima_checked,
  output int         frame_ends_checked
);
  import lmf_pkg::*;

  pixel_t  row_above [MAX_SIDE];
  pixel_t  row_prev  [MAX_SIDE];
  pixel_t  win       [9];
  int      side_reg;
  int      row_pos;
  int      col_pos;
  result_t maxima_due [$];

  initial begin
    fail_count         = 0;
    pending            = 0;
    maxima_checked     = 0;
    frame_ends_checked = 0;
    side_reg           = MAX_SIDE;
    row_pos            = 0;
    col_pos            = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic take_pixel(input pixel_t px);
    int      s;
    int      r;
    int      c;
    int      k;
    pixel_t  top;
    pixel_t  mid;
    pixel_t  best;
    result_t res;
    s = (side_reg < SIDE_MIN) ? SIDE_MIN : (side_reg > MAX_SIDE) ? MAX_SIDE : side_reg;
    r = (row_pos >= s) ? 0 : row_pos;
    c = (col_pos >= s) ? 0 : col_pos;
    top = row_above[c];
    mid = row_prev[c];
    row_above[c] = mid;
    row_prev[c]  = px;
    // cells 0..2 hold row r-2, 3..5 row r-1, 6..8 row r; oldest column first
    for (k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    if (r >= 2 && c >= 2) begin
      best = win[0];
      for (k = 1; k < 9; k++) begin
        if (win[k] > best) best = win[k];
      end
      res.local_max = best;
      res.frame_end = (r == s - 1) && (c == s - 1);
      maxima_due.push_back(res);
    end
    c++;
    if (c >= s) begin
      c = 0;
      r++;
      if (r >= s) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      side_reg = SIDE_RESET;
      row_pos  = 0;
      col_pos  = 0;
      maxima_due.delete();
    end else begin
      if (cfg_write) begin
        side_reg = cfg_data;
        row_pos  = 0;
        col_pos  = 0;
      end
      if (in_valid && !in_stall) take_pixel(pixel);
      if (out_valid && !out_stall) begin
        if (maxima_due.size() == 0) begin
          report_mismatch("unexpected result, local_max", local_max, -1);
        end else begin
          want = maxima_due.pop_front();
          maxima_checked++;
          if (want.frame_end) frame_ends_checked++;
          if (local_max !== want.local_max) begin
            report_mismatch("local_max", local_max, want.local_max);
          end
          if (frame_end !== want.frame_end) begin
            report_mismatch("frame_end", frame_end, want.frame_end);
          end
        end
      end
    end
    pending = maxima_due.size();
  end

endmodule

// File: sim/tb.sv
// Testbench top for local_max_filter_3x3_core: clock, reset, pixel stream,
// side register writes and output backpressure; verdict at the end.
// Depends on lmf_pkg and max_window_checker.
module tb;
  import lmf_pkg::*;

  localparam int ITEM_TARGET = 1450;
  localparam int SETTLE      = 8;
  localparam int LONG_HOLD   = 80;
  localparam int IDLE_LIMIT  = 1000;

  typedef enum int {PIX_ANY, PIX_CLOSE, PIX_SPARSE, PIX_LISTED} pix_mix_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  pixel_t     pixel;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] local_max;
  logic       frame_end;
  logic       squeeze;

  int     fail_count;
  int     pending;
  int     maxima_checked;
  int     frame_ends_checked;
  int     pixels_sent = 0;
  int     phases_run  = 0;
  pixel_t listed_pixels [$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  local_max_filter_3x3_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .local_max (local_max),
    .frame_end (frame_end)
  );

  max_window_checker scoreboard (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .pixel              (pixel),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .local_max          (local_max),
    .frame_end          (frame_end),
    .fail_count         (fail_count),
    .pending            (pending),
    .maxima_checked     (maxima_checked),
    .frame_ends_checked (frame_ends_checked)
  );

  // mostly short pauses, now and then a long one
  function automatic int pause_len();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return $urandom_range(1, 3);
    if (roll < 9) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic pixel_t next_pixel(input pix_mix_t mix, input pixel_t base);
    case (mix)
      PIX_CLOSE:  return base ^ pixel_t'($urandom_range(0, 3));
      PIX_SPARSE: return ($urandom_range(0, 15) == 0) ? 8'd255 : pixel_t'($urandom_range(0, 7));
      PIX_LISTED: return listed_pixels.pop_front();
      default:    return pixel_t'($urandom_range(0, 255));
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_pixel(input pixel_t p, input bit paced);
    int g;
    g = (paced && $urandom_range(0, 2) == 0) ? pause_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  // block is idle on entry: set the side, stream, then drain before returning
  task automatic run_phase(input logic [7:0] side_code, input int count,
                           input pix_mix_t mix, input bit paced);
    int     k;
    pixel_t base;
    cfg_write <= 1'b1;
    cfg_data  <= side_code;
    @(negedge clk);
    cfg_write <= 1'b0;
    base = pixel_t'($urandom_range(0, 255));
    for (k = 0; k < count; k++) send_pixel(next_pixel(mix, base), paced);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    phases_run++;
  endtask

  initial begin : receiver
    int stall_left;
    int quiet_left;
    bit long_done;
    stall_left = 0;
    quiet_left = 0;
    long_done  = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !long_done) begin
        // long hold-off so the result queue fills and the input stalls
        long_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (quiet_left > 0) quiet_left--;
        else if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(20, 60);
        else if ($urandom_range(0, 2) == 0) stall_left = pause_len();
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] side_code;
    int         eff;
    int         count;
    int         round;
    int         pick;
    int         side_lo;
    int         side_hi;
    pix_mix_t   mix;
    bit         paced;
    rst       = 1'b1;
    in_valid  = 1'b0;
    pixel     = '0;
    cfg_write = 1'b0;
    cfg_data  = '0;
    squeeze   = 1'b0;
    side_lo   = MAX_SIDE;
    side_hi   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // side 3: max at the newest pixel, then at the oldest corner (line store path),
    // then a partial frame that the next side write cuts off
    listed_pixels = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd255,
                      8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                      8'd9, 8'd200, 8'd17, 8'd3};
    run_phase(8'd3, listed_pixels.size(), PIX_LISTED, 1'b0);
    side_lo = 3;
    side_hi = 3;

    for (round = 0; pixels_sent < ITEM_TARGET; round++) begin
      squeeze <= (round == 2);
      pick  = $urandom_range(0, 9);
      mix   = pix_mix_t'($urandom_range(0, 2));
      paced = ($urandom_range(0, 3) != 0);
      case (round)
        0:       side_code = 8'd255;
        1:       side_code = 8'd0;
        2:       side_code = 8'd10;
        3:       side_code = 8'd2;
        4:       side_code = 8'd128;
        5:       side_code = 8'd1;
        default: begin
          if (pick < 8)      side_code = 8'($urandom_range(3, 12));
          else if (pick < 9) side_code = 8'($urandom_range(13, 40));
          else               side_code = 8'($urandom_range(0, 3));
        end
      endcase
      eff = (side_code < SIDE_MIN) ? SIDE_MIN : (side_code > MAX_SIDE) ? MAX_SIDE : side_code;
      if (round == 2) begin
        count = 3 * eff * eff;
        mix   = PIX_ANY;
        paced = 1'b0;
      end else if (eff <= 12) begin
        count = $urandom_range(1, 3) * eff * eff;
        if ($urandom_range(0, 3) == 0) count += $urandom_range(1, eff * eff - 1);
      end else begin
        // big sides: only a few rows, enough to reach the interior
        count = 2 * eff + $urandom_range(3, eff);
      end
      if (count > ITEM_TARGET - pixels_sent) count = ITEM_TARGET - pixels_sent;
      if (eff < side_lo) side_lo = eff;
      if (eff > side_hi) side_hi = eff;
      run_phase(side_code, count, mix, paced);
    end

    repeat (SETTLE) @(negedge clk);
    $display("run: %0d pixels over %0d side settings, effective side %0d to %0d",
             pixels_sent, phases_run, side_lo, side_hi);
    $display("run: %0d window maxima checked, %0d frame ends, %0d mismatches",
             maxima_checked, frame_ends_checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/lmf_pkg.sv
src/lmf_line_store.sv
src/lmf_window_cell.sv
src/lmf_out_queue.sv
src/local_max_filter_3x3_core.sv
sim/max_window_checker.sv
sim/tb.sv
